// File: hdl/lbmc_pkg.sv
// Shared types, constants and fixed-point helpers for the D2Q9 node collision pipeline.
// Used by lbm_d2q9_node_collision and its checker and testbench; depends on nothing else.
package lbmc_pkg;

    localparam int FRAC = 20;

    localparam logic [63:0] ONE_FX  = 64'd1 << FRAC;
    localparam logic [63:0] HALF_FX = 64'd1 << (FRAC - 1);
    localparam logic [63:0] LIM_FX  = (64'd1 << (FRAC + 16)) - 64'd1;

    // lattice weights, rounded to nearest
    localparam logic [19:0] W_REST = 20'((8 * ONE_FX + 64'd9) / 64'd18);
    localparam logic [19:0] W_AXIS = 20'((2 * ONE_FX + 64'd9) / 64'd18);
    localparam logic [19:0] W_DIAG = 20'((2 * ONE_FX + 64'd36) / 64'd72);

    localparam logic [21:0] INV_RELAX_RST = 22'(ONE_FX);

    // register indexes
    localparam logic [1:0] CFG_INV_RELAX = 2'd0;
    localparam logic [1:0] CFG_FORCE_X   = 2'd1;
    localparam logic [1:0] CFG_FORCE_Y   = 2'd2;

    // lattice direction components
    localparam logic [1:0] DIR_ZERO = 2'b00;
    localparam logic [1:0] DIR_POS  = 2'b01;
    localparam logic [1:0] DIR_NEG  = 2'b11;

    localparam logic [1:0] DIR_X [9] = '{DIR_ZERO, DIR_POS, DIR_ZERO, DIR_NEG, DIR_ZERO,
                                         DIR_POS, DIR_NEG, DIR_NEG, DIR_POS};
    localparam logic [1:0] DIR_Y [9] = '{DIR_ZERO, DIR_ZERO, DIR_POS, DIR_ZERO, DIR_NEG,
                                         DIR_POS, DIR_POS, DIR_NEG, DIR_NEG};

    typedef logic signed [36:0] q37_t;

    typedef struct packed {
        logic signed [23:0] dist_0;
        logic signed [23:0] dist_1;
        logic signed [23:0] dist_2;
        logic signed [23:0] dist_3;
        logic signed [23:0] dist_4;
        logic signed [23:0] dist_5;
        logic signed [23:0] dist_6;
        logic signed [23:0] dist_7;
        logic signed [23:0] dist_8;
    } in_word_t;

    typedef struct packed {
        logic signed [23:0] post_0;
        logic signed [23:0] post_1;
        logic signed [23:0] post_2;
        logic signed [23:0] post_3;
        logic signed [23:0] post_4;
        logic signed [23:0] post_5;
        logic signed [23:0] post_6;
        logic signed [23:0] post_7;
        logic signed [23:0] post_8;
        logic        [22:0] density;
        logic signed [23:0] vel_x;
        logic signed [23:0] vel_y;
    } out_word_t;

    // weight group: 0 rest, 1 axis, 2 diagonal
    function automatic logic [1:0] wsel(input int i);
        if (i == 0)
            return 2'd0;
        else if (i < 5)
            return 2'd1;
        return 2'd2;
    endfunction

    function automatic logic [19:0] w_of(input logic [1:0] grp);
        logic [19:0] w;
        case (grp)
            2'd0:    w = W_REST;
            2'd1:    w = W_AXIS;
            default: w = W_DIAG;
        endcase
        return w;
    endfunction

    // round magnitude to nearest (ties away), clamp, apply sign
    function automatic q37_t rnd_sat(input logic [63:0] mag, input logic neg);
        logic [63:0] r;
        q37_t        m;
        r = (mag + HALF_FX) >> FRAC;
        if (r > LIM_FX)
            r = LIM_FX;
        m = signed'(r[36:0]);
        return neg ? -m : m;
    endfunction

    function automatic q37_t fmul25(input logic signed [24:0] a, input logic signed [24:0] b);
        logic [24:0] ma;
        logic [24:0] mb;
        logic [49:0] p;
        ma = a[24] ? unsigned'(-a) : unsigned'(a);
        mb = b[24] ? unsigned'(-b) : unsigned'(b);
        p  = ma * mb;
        return rnd_sat(64'(p), a[24] ^ b[24]);
    endfunction

    function automatic q37_t fmulw(input logic [19:0] w, input logic signed [33:0] b);
        logic [33:0] mb;
        logic [53:0] p;
        mb = b[33] ? unsigned'(-b) : unsigned'(b);
        p  = w * mb;
        return rnd_sat(64'(p), b[33]);
    endfunction

    function automatic q37_t fmulg(input logic signed [21:0] g, input logic signed [32:0] b);
        logic [21:0] mg;
        logic [32:0] mb;
        logic [54:0] p;
        mg = g[21] ? unsigned'(-g) : unsigned'(g);
        mb = b[32] ? unsigned'(-b) : unsigned'(b);
        p  = mg * mb;
        return rnd_sat(64'(p), g[21] ^ b[32]);
    endfunction

    function automatic logic signed [24:0] dsel(input logic signed [23:0] v,
                                                input logic [1:0] dir);
        logic signed [24:0] r;
        case (dir)
            DIR_POS: r = 25'(v);
            DIR_NEG: r = -25'(v);
            default: r = '0;
        endcase
        return r;
    endfunction

    // halve with rounding away from zero
    function automatic logic signed [23:0] halve24(input logic signed [23:0] v);
        logic [23:0] m;
        logic [24:0] h;
        m = v[23] ? unsigned'(-v) : unsigned'(v);
        h = ({1'b0, m} + 25'd1) >> 1;
        return v[23] ? -signed'(h[23:0]) : signed'(h[23:0]);
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [38:0] v);
        if (v > 39'sd8388607)
            return 24'sh7FFFFF;
        else if (v < -39'sd8388608)
            return 24'sh800000;
        return v[23:0];
    endfunction

endpackage

// File: hdl/lbm_d2q9_node_collision.sv
// D2Q9 lattice Boltzmann BGK collision with Guo forcing, one node per word.
// One word per cycle sustained while no result word is stalled at the output.
// The quotient divider (4 quotient bits per stage, 6 stages) sets the depth.
// The whole pipeline holds while a result word is stalled at the output.
// Reset (rst_n low, asynchronous) empties the pipeline and loads inv_relax = 1.0,
// force_x = force_y = 0. Depends on lbmc_pkg.
module lbm_d2q9_node_collision (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  lbmc_pkg::in_word_t item,
    output logic               result_valid,
    input  logic               result_stall,
    output lbmc_pkg::out_word_t result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_data
);
    import lbmc_pkg::*;

    // Stage map: A input, B moments, C0..C6 divider, D velocity/projections,
    // E products, F sums, G poly/forcing bracket, H weight products,
    // I equilibrium/source, J relax partial products, K relax term, L output.
    localparam int NST      = 18;
    localparam int DIV_STG  = 7;
    localparam int BITS_PER = 4;
    localparam int QBITS    = 24;

    typedef struct packed {
        logic        neg;
        logic        ovf;
        logic [27:0] mag;
        logic [26:0] rem;
        logic [23:0] quo;
    } div_lane_t;

    typedef struct {
        logic signed [23:0] d [9];
        logic signed [27:0] rho;
        logic signed [27:0] mx;
        logic signed [27:0] my;
    } st_b_t;

    typedef struct {
        logic signed [23:0] d [9];
        logic signed [27:0] rho;
        logic               pos;
        div_lane_t          dx;
        div_lane_t          dy;
    } st_c_t;

    typedef struct {
        logic signed [23:0] d [9];
        logic signed [27:0] rho;
        logic signed [23:0] ux;
        logic signed [23:0] uy;
        logic signed [24:0] cu [9];
        logic signed [24:0] cf [9];
    } st_d_t;

    typedef struct {
        logic signed [23:0] d [9];
        logic signed [27:0] rho;
        logic signed [23:0] ux;
        logic signed [23:0] uy;
        logic signed [24:0] cu [9];
        logic signed [24:0] cf [9];
        logic signed [29:0] uxfx;
        logic signed [29:0] uyfy;
        logic signed [29:0] uxux;
        logic signed [29:0] uyuy;
        logic signed [29:0] cu2 [9];
        logic signed [29:0] cucf [9];
        logic signed [26:0] wr [3];
    } st_e_t;

    typedef struct {
        logic signed [23:0] d [9];
        logic signed [27:0] rho;
        logic signed [23:0] ux;
        logic signed [23:0] uy;
        logic signed [24:0] cu [9];
        logic signed [24:0] cf [9];
        logic signed [26:0] wr [3];
        logic signed [29:0] uf;
        logic signed [29:0] h3usq;
        logic signed [31:0] h9cu2 [9];
        logic signed [33:0] n9cucf [9];
    } st_f_t;

    typedef struct {
        logic signed [23:0] d [9];
        logic signed [27:0] rho;
        logic signed [23:0] ux;
        logic signed [23:0] uy;
        logic signed [26:0] wr [3];
        logic signed [32:0] poly [9];
        logic signed [33:0] br [9];
    } st_g_t;

    typedef struct {
        logic signed [23:0] d [9];
        logic signed [27:0] rho;
        logic signed [23:0] ux;
        logic signed [23:0] uy;
        logic signed [32:0] wb [9];
        logic [43:0]        fp_lo [9];
        logic [42:0]        fp_hi [9];
        logic               fneg [9];
    } st_h_t;

    typedef struct {
        logic signed [23:0] d [9];
        logic signed [27:0] rho;
        logic signed [23:0] ux;
        logic signed [23:0] uy;
        q37_t               feq [9];
        logic signed [32:0] src [9];
    } st_i_t;

    typedef struct {
        logic signed [23:0] d [9];
        logic signed [27:0] rho;
        logic signed [23:0] ux;
        logic signed [23:0] uy;
        logic signed [32:0] src [9];
        logic [39:0]        ip_lo [9];
        logic [39:0]        ip_hi [9];
        logic               ineg [9];
    } st_j_t;

    typedef struct {
        logic signed [23:0] d [9];
        logic signed [27:0] rho;
        logic signed [23:0] ux;
        logic signed [23:0] uy;
        logic signed [32:0] src [9];
        q37_t               t [9];
    } st_k_t;

    localparam logic signed [37:0] LIM38 = 38'(LIM_FX);

    // ---------------- configuration ----------------
    logic        [21:0] inv_relax_reg;
    logic signed [23:0] force_x_reg;
    logic signed [23:0] force_y_reg;
    logic signed [21:0] g_reg;     // 1 - inv_relax/2, follows the register
    logic signed [21:0] g_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_relax_reg <= INV_RELAX_RST;
            force_x_reg   <= '0;
            force_y_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_INV_RELAX: inv_relax_reg <= cfg_data[21:0];
                CFG_FORCE_X:   force_x_reg   <= signed'(cfg_data);
                CFG_FORCE_Y:   force_y_reg   <= signed'(cfg_data);
                default:       ;   // index past the register list: dropped
            endcase
        end
    end

    always_comb
    begin
        logic [22:0] hinv;
        logic [23:0] gw;
        hinv   = ({1'b0, inv_relax_reg} + 23'd1) >> 1;
        gw     = 24'(ONE_FX) - {1'b0, hinv};
        g_next = signed'(gw[21:0]);
    end

    // ---------------- flow control ----------------
    // Global enable: every stage moves when the output word is free or being taken.
    logic [NST-1:0] vld_reg;
    logic           adv;

    assign adv          = !(vld_reg[NST-1] && result_stall);
    assign item_stall   = !adv;
    assign result_valid = vld_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NST-2:0], item_valid};
    end

    // ---------------- stage registers ----------------
    logic signed [23:0] a_reg [9];
    logic signed [23:0] a_next [9];
    st_b_t     b_reg, b_next;
    st_c_t     c_reg [DIV_STG];
    st_c_t     c_next [DIV_STG];
    st_d_t     d_reg, d_next;
    st_e_t     e_reg, e_next;
    st_f_t     f_reg, f_next;
    st_g_t     g_st_reg, g_st_next;
    st_h_t     h_reg, h_next;
    st_i_t     i_reg, i_next;
    st_j_t     j_reg, j_next;
    st_k_t     k_reg, k_next;
    out_word_t res_reg, res_next;

    always_ff @(posedge clk)
    begin
        g_reg <= g_next;
        if (adv)
        begin
            a_reg    <= a_next;
            b_reg    <= b_next;
            c_reg    <= c_next;
            d_reg    <= d_next;
            e_reg    <= e_next;
            f_reg    <= f_next;
            g_st_reg <= g_st_next;
            h_reg    <= h_next;
            i_reg    <= i_next;
            j_reg    <= j_next;
            k_reg    <= k_next;
            res_reg  <= res_next;
        end
    end

    assign result = res_reg;

    // A: capture input word
    always_comb
    begin
        a_next[0] = item.dist_0;
        a_next[1] = item.dist_1;
        a_next[2] = item.dist_2;
        a_next[3] = item.dist_3;
        a_next[4] = item.dist_4;
        a_next[5] = item.dist_5;
        a_next[6] = item.dist_6;
        a_next[7] = item.dist_7;
        a_next[8] = item.dist_8;
    end

    // B: density and force-corrected momentum
    always_comb
    begin
        logic signed [27:0] acc;
        acc = '0;
        for (int i = 0; i < 9; i++)
            acc = acc + 28'(a_reg[i]);
        b_next.d   = a_reg;
        b_next.rho = acc;
        b_next.mx  = (28'(a_reg[1]) + 28'(a_reg[5]) + 28'(a_reg[8]))
                   - (28'(a_reg[3]) + 28'(a_reg[6]) + 28'(a_reg[7]))
                   + 28'(halve24(force_x_reg));
        b_next.my  = (28'(a_reg[2]) + 28'(a_reg[5]) + 28'(a_reg[6]))
                   - (28'(a_reg[4]) + 28'(a_reg[7]) + 28'(a_reg[8]))
                   + 28'(halve24(force_y_reg));
    end

    // C: restoring divider, |m| * 2^FRAC / rho, BITS_PER quotient bits per stage
    function automatic div_lane_t div_setup(input logic signed [27:0] m,
                                            input logic signed [27:0] rho);
        div_lane_t s;
        s.neg = m[27];
        s.mag = m[27] ? unsigned'(-m) : unsigned'(m);
        s.ovf = {3'b000, s.mag} >= {rho[26:0], 4'b0000};   // quotient >= 2^24
        s.rem = {3'b000, s.mag[27:4]};
        s.quo = '0;
        return s;
    endfunction

    function automatic div_lane_t div_step(input div_lane_t s, input logic [27:0] den,
                                           input logic [4:0] k);
        div_lane_t   r;
        logic [23:0] nsrc;
        logic [27:0] t;
        r    = s;
        nsrc = {s.mag[3:0], 20'd0};
        t    = {s.rem, nsrc[k]};
        if (t >= den)
        begin
            r.rem = 27'(t - den);
            r.quo = {s.quo[22:0], 1'b1};
        end
        else
        begin
            r.rem = t[26:0];
            r.quo = {s.quo[22:0], 1'b0};
        end
        return r;
    endfunction

    always_comb
    begin
        logic [27:0] den;
        c_next[0].d   = b_reg.d;
        c_next[0].rho = b_reg.rho;
        c_next[0].pos = (b_reg.rho > 28'sd0);
        c_next[0].dx  = div_setup(b_reg.mx, b_reg.rho);
        c_next[0].dy  = div_setup(b_reg.my, b_reg.rho);
        for (int j = 1; j < DIV_STG; j++)
        begin
            c_next[j] = c_reg[j-1];
            den       = {1'b0, c_reg[j-1].rho[26:0]};
            for (int s = 0; s < BITS_PER; s++)
            begin
                c_next[j].dx = div_step(c_next[j].dx, den,
                                        5'(QBITS - 1 - BITS_PER * (j - 1) - s));
                c_next[j].dy = div_step(c_next[j].dy, den,
                                        5'(QBITS - 1 - BITS_PER * (j - 1) - s));
            end
        end
    end

    // D: saturate quotients, project on lattice directions
    function automatic logic signed [23:0] vel_fin(input div_lane_t s, input logic pos);
        logic signed [23:0] v;
        if (!pos)
            v = '0;
        else if (s.ovf || s.quo[23])
            v = s.neg ? 24'sh800000 : 24'sh7FFFFF;
        else
            v = s.neg ? -signed'({1'b0, s.quo[22:0]}) : signed'({1'b0, s.quo[22:0]});
        return v;
    endfunction

    always_comb
    begin
        logic signed [23:0] ux;
        logic signed [23:0] uy;
        ux         = vel_fin(c_reg[DIV_STG-1].dx, c_reg[DIV_STG-1].pos);
        uy         = vel_fin(c_reg[DIV_STG-1].dy, c_reg[DIV_STG-1].pos);
        d_next.d   = c_reg[DIV_STG-1].d;
        d_next.rho = c_reg[DIV_STG-1].rho;
        d_next.ux  = ux;
        d_next.uy  = uy;
        for (int i = 0; i < 9; i++)
        begin
            d_next.cu[i] = dsel(ux, DIR_X[i]) + dsel(uy, DIR_Y[i]);
            d_next.cf[i] = dsel(force_x_reg, DIR_X[i]) + dsel(force_y_reg, DIR_Y[i]);
        end
    end

    // E: first round of products
    always_comb
    begin
        q37_t p;
        e_next.d   = d_reg.d;
        e_next.rho = d_reg.rho;
        e_next.ux  = d_reg.ux;
        e_next.uy  = d_reg.uy;
        e_next.cu  = d_reg.cu;
        e_next.cf  = d_reg.cf;
        p = fmul25(25'(d_reg.ux), 25'(force_x_reg));  e_next.uxfx = p[29:0];
        p = fmul25(25'(d_reg.uy), 25'(force_y_reg));  e_next.uyfy = p[29:0];
        p = fmul25(25'(d_reg.ux), 25'(d_reg.ux));     e_next.uxux = p[29:0];
        p = fmul25(25'(d_reg.uy), 25'(d_reg.uy));     e_next.uyuy = p[29:0];
        for (int i = 0; i < 9; i++)
        begin
            p = fmul25(d_reg.cu[i], d_reg.cu[i]);
            e_next.cu2[i] = p[29:0];
            p = fmul25(d_reg.cu[i], d_reg.cf[i]);
            e_next.cucf[i] = p[29:0];
        end
        for (int w = 0; w < 3; w++)
        begin
            p = fmulw(w_of(2'(w)), 34'(d_reg.rho));
            e_next.wr[w] = p[26:0];
        end
    end

    // F: u.F, |u|^2 and scaled squares
    always_comb
    begin
        logic signed [30:0] usq;
        logic signed [31:0] h3;
        logic signed [33:0] h9;
        f_next.d   = e_reg.d;
        f_next.rho = e_reg.rho;
        f_next.ux  = e_reg.ux;
        f_next.uy  = e_reg.uy;
        f_next.cu  = e_reg.cu;
        f_next.cf  = e_reg.cf;
        f_next.wr  = e_reg.wr;
        f_next.uf  = e_reg.uxfx + e_reg.uyfy;
        usq        = 31'(e_reg.uxux) + 31'(e_reg.uyuy);
        h3         = (32'(usq) * 32'sd3 + 32'sd1) >>> 1;
        f_next.h3usq = h3[29:0];
        for (int i = 0; i < 9; i++)
        begin
            h9 = (34'(e_reg.cu2[i]) * 34'sd9 + 34'sd1) >>> 1;
            f_next.h9cu2[i]  = h9[31:0];
            f_next.n9cucf[i] = 34'(e_reg.cucf[i]) * 34'sd9;
        end
    end

    // G: equilibrium polynomial and forcing bracket
    always_comb
    begin
        logic signed [35:0] pw;
        logic signed [35:0] bw;
        g_st_next.d   = f_reg.d;
        g_st_next.rho = f_reg.rho;
        g_st_next.ux  = f_reg.ux;
        g_st_next.uy  = f_reg.uy;
        g_st_next.wr  = f_reg.wr;
        for (int i = 0; i < 9; i++)
        begin
            pw = signed'(36'(ONE_FX)) + 36'(f_reg.cu[i]) * 36'sd3
               + 36'(f_reg.h9cu2[i]) - 36'(f_reg.h3usq);
            bw = (36'(f_reg.cf[i]) - 36'(f_reg.uf)) * 36'sd3 + 36'(f_reg.n9cucf[i]);
            g_st_next.poly[i] = pw[32:0];
            g_st_next.br[i]   = bw[33:0];
        end
    end

    // H: weighted bracket; w*rho times poly split into two partial products
    always_comb
    begin
        q37_t        p;
        logic [26:0] mw;
        logic [32:0] mp;
        h_next.d   = g_st_reg.d;
        h_next.rho = g_st_reg.rho;
        h_next.ux  = g_st_reg.ux;
        h_next.uy  = g_st_reg.uy;
        for (int i = 0; i < 9; i++)
        begin
            p = fmulw(w_of(wsel(i)), g_st_reg.br[i]);
            h_next.wb[i] = p[32:0];
            mw = g_st_reg.wr[wsel(i)][26] ? unsigned'(-g_st_reg.wr[wsel(i)])
                                          : unsigned'(g_st_reg.wr[wsel(i)]);
            mp = g_st_reg.poly[i][32] ? unsigned'(-g_st_reg.poly[i])
                                      : unsigned'(g_st_reg.poly[i]);
            h_next.fp_lo[i] = mw * mp[16:0];
            h_next.fp_hi[i] = mw * mp[32:17];
            h_next.fneg[i]  = g_st_reg.wr[wsel(i)][26] ^ g_st_reg.poly[i][32];
        end
    end

    // I: equilibrium and source term
    always_comb
    begin
        q37_t p;
        i_next.d   = h_reg.d;
        i_next.rho = h_reg.rho;
        i_next.ux  = h_reg.ux;
        i_next.uy  = h_reg.uy;
        for (int i = 0; i < 9; i++)
        begin
            i_next.feq[i] = rnd_sat(64'(h_reg.fp_lo[i]) + (64'(h_reg.fp_hi[i]) << 17),
                                    h_reg.fneg[i]);
            p = fmulg(g_reg, h_reg.wb[i]);
            i_next.src[i] = p[32:0];
        end
    end

    // J: clamped non-equilibrium part times inv_relax, two partial products
    always_comb
    begin
        logic signed [37:0] df;
        logic [35:0]        md;
        j_next.d   = i_reg.d;
        j_next.rho = i_reg.rho;
        j_next.ux  = i_reg.ux;
        j_next.uy  = i_reg.uy;
        j_next.src = i_reg.src;
        for (int i = 0; i < 9; i++)
        begin
            df = 38'(i_reg.d[i]) - 38'(i_reg.feq[i]);
            if (df > LIM38)
                df = LIM38;
            else if (df < -LIM38)
                df = -LIM38;
            md = df[37] ? 36'(unsigned'(-df)) : 36'(unsigned'(df));
            j_next.ip_lo[i] = inv_relax_reg * md[17:0];
            j_next.ip_hi[i] = inv_relax_reg * md[35:18];
            j_next.ineg[i]  = df[37];
        end
    end

    // K: relaxation term
    always_comb
    begin
        k_next.d   = j_reg.d;
        k_next.rho = j_reg.rho;
        k_next.ux  = j_reg.ux;
        k_next.uy  = j_reg.uy;
        k_next.src = j_reg.src;
        for (int i = 0; i < 9; i++)
            k_next.t[i] = rnd_sat(64'(j_reg.ip_lo[i]) + (64'(j_reg.ip_hi[i]) << 18),
                                  j_reg.ineg[i]);
    end

    // L: post-collision values and output word
    always_comb
    begin
        logic signed [23:0] post [9];
        for (int i = 0; i < 9; i++)
            post[i] = sat24(39'(k_reg.d[i]) - 39'(k_reg.t[i]) + 39'(k_reg.src[i]));
        res_next.post_0 = post[0];
        res_next.post_1 = post[1];
        res_next.post_2 = post[2];
        res_next.post_3 = post[3];
        res_next.post_4 = post[4];
        res_next.post_5 = post[5];
        res_next.post_6 = post[6];
        res_next.post_7 = post[7];
        res_next.post_8 = post[8];
        if (k_reg.rho[27])
            res_next.density = '0;
        else if (k_reg.rho > 28'sd8388607)
            res_next.density = '1;
        else
            res_next.density = k_reg.rho[22:0];
        res_next.vel_x = k_reg.ux;
        res_next.vel_y = k_reg.uy;
    end

    // ---------------- checks ----------------
    // a blocked output word freezes the whole pipe, input included
    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |-> item_stall)
        else $error("input taken while output word blocked");

    // non-positive density must come out with zero velocity
    a_zero_vel: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.density == '0 |-> result.vel_x == '0 && result.vel_y == '0)
        else $error("nonzero velocity with zero density");

    // a word in the last inner stage reaches the output on the next move
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NST-2] && !item_stall |=> result_valid)
        else $error("word lost before output stage");

endmodule

// File: tb/lbm_d2q9_node_collision_checker.sv
// Checker for the D2Q9 node collision block: tracks register writes, predicts each
// node's result word and compares it with what comes out. Depends on lbmc_pkg.
module lbm_d2q9_node_collision_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic                item_stall,
    input  lbmc_pkg::in_word_t  item,
    input  logic                result_valid,
    input  logic                result_stall,
    input  lbmc_pkg::out_word_t result,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [23:0]         cfg_data,
    output int                  mismatches,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import lbmc_pkg::*;

    localparam longint UNIT = 64'sd1 << 20;
    localparam longint CAP  = (64'sd1 << 36) - 1;
    localparam longint WT_REST = (8 * UNIT + 9) / 18;
    localparam longint WT_AXIS = (2 * UNIT + 9) / 18;
    localparam longint WT_DIAG = (2 * UNIT + 36) / 72;
    localparam int EX [9] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
    localparam int EY [9] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};

    logic [21:0]        relax_q;
    logic signed [23:0] fx_q;
    logic signed [23:0] fy_q;
    out_word_t          node_results [$];

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint cap36(longint v);
        return clip(v, -CAP, CAP);
    endfunction

    function automatic longint half_away(longint v);
        longint m;
        m = v < 0 ? -v : v;
        m = (m + 1) >>> 1;
        return v < 0 ? -m : m;
    endfunction

    // exact product, rounded ties away from zero, clamped
    function automatic longint qmul(longint a, longint b);
        logic [127:0] p;
        longint       ma;
        longint       mb;
        bit           neg;
        a = cap36(a);
        b = cap36(b);
        neg = (a < 0) != (b < 0);
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        p = 128'(ma) * 128'(mb);
        p = (p + (128'd1 << 19)) >> 20;
        if (p > 128'(CAP))
            p = 128'(CAP);
        return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    // num / den in Q.20, truncated, capped at 2^24 then saturated
    function automatic longint qdiv(longint num, longint den);
        longint m;
        longint q;
        m = num < 0 ? -num : num;
        q = (m << 20) / den;
        if (q > (64'sd1 << 24))
            q = 64'sd1 << 24;
        return clip(num < 0 ? -q : q, -8388608, 8388607);
    endfunction

    function automatic out_word_t collide(in_word_t w);
        longint    d [9];
        longint    rho, mx, my, ux, uy, fx, fy, inv, g, uf, usq;
        longint    wt, cu, cf, poly, feq, br, src, post;
        logic [23:0] posts [9];
        out_word_t r;
        d = '{w.dist_0, w.dist_1, w.dist_2, w.dist_3, w.dist_4,
              w.dist_5, w.dist_6, w.dist_7, w.dist_8};
        fx = fx_q;
        fy = fy_q;
        inv = longint'({42'd0, relax_q});
        rho = 0;
        for (int i = 0; i < 9; i++)
            rho += d[i];
        mx = (d[1] + d[5] + d[8]) - (d[3] + d[6] + d[7]) + half_away(fx);
        my = (d[2] + d[5] + d[6]) - (d[4] + d[7] + d[8]) + half_away(fy);
        ux = 0;
        uy = 0;
        if (rho > 0)
        begin
            ux = qdiv(mx, rho);
            uy = qdiv(my, rho);
        end
        uf = cap36(qmul(ux, fx) + qmul(uy, fy));
        usq = cap36(qmul(ux, ux) + qmul(uy, uy));
        g = cap36(UNIT - half_away(inv));
        for (int i = 0; i < 9; i++)
        begin
            wt = i == 0 ? WT_REST : (i < 5 ? WT_AXIS : WT_DIAG);
            cu = EX[i] * ux + EY[i] * uy;
            cf = EX[i] * fx + EY[i] * fy;
            poly = cap36(UNIT + 3 * cu + half_away(9 * qmul(cu, cu)) - half_away(3 * usq));
            feq = qmul(qmul(wt, rho), poly);
            br = cap36(3 * (cf - uf) + 9 * qmul(cu, cf));
            src = qmul(g, qmul(wt, br));
            post = clip(d[i] - qmul(inv, cap36(d[i] - feq)) + src, -8388608, 8388607);
            posts[i] = post[23:0];
        end
        r = {posts[0], posts[1], posts[2], posts[3], posts[4], posts[5], posts[6],
             posts[7], posts[8], 23'(clip(rho, 0, 8388607)), ux[23:0], uy[23:0]};
        return r;
    endfunction

    task automatic report(string field, longint got, longint want);
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, field, got, want);
        mismatches++;
    endtask

    task automatic check_field(string field, longint got, longint want);
        if (got != want)
            report(field, got, want);
    endtask

    initial
    begin
        mismatches = 0;
        pending = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relax_q <= INV_RELAX_RST;
            fx_q <= '0;
            fy_q <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_INV_RELAX: relax_q <= cfg_data[21:0];
                CFG_FORCE_X:   fx_q <= cfg_data;
                CFG_FORCE_Y:   fy_q <= cfg_data;
                default:       ;
            endcase
        end
    end

    always @(posedge clk)
    begin
        out_word_t e;
        if (rst_n && item_valid && !item_stall)
            node_results.push_back(collide(item));
        if (rst_n && result_valid && !result_stall)
        begin
            if (node_results.size() == 0)
                report("unexpected word", 0, 0);
            else
            begin
                e = node_results.pop_front();
                check_field("post_0", result.post_0, e.post_0);
                check_field("post_1", result.post_1, e.post_1);
                check_field("post_2", result.post_2, e.post_2);
                check_field("post_3", result.post_3, e.post_3);
                check_field("post_4", result.post_4, e.post_4);
                check_field("post_5", result.post_5, e.post_5);
                check_field("post_6", result.post_6, e.post_6);
                check_field("post_7", result.post_7, e.post_7);
                check_field("post_8", result.post_8, e.post_8);
                check_field("density", result.density, e.density);
                check_field("vel_x", result.vel_x, e.vel_x);
                check_field("vel_y", result.vel_y, e.vel_y);
            end
        end
        pending = node_results.size();
    end

endmodule

// File: tb/lbm_d2q9_node_collision_tb.sv
// Top of the node collision testbench: clock, reset, register writes, node stimulus
// and output stall patterns. Depends on lbmc_pkg and lbm_d2q9_node_collision_checker.
module lbm_d2q9_node_collision_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lbmc_pkg::*;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      item_valid = 1'b0;
    logic      item_stall;
    in_word_t  item = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    out_word_t result;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;
    int        mismatches;
    int        pending;

    // receiver behavior: 0 never stalls, 1 random stalls, 2 fixed duty pattern
    int        stall_mode = 0;
    bit        hold_armed = 0;
    int        hold_left = 0;
    int        cyc = 0;

    localparam int ONE = 1 << 20;

    always #5 clk = ~clk;

    lbm_d2q9_node_collision DUT (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .result_valid(result_valid), .result_stall(result_stall), .result(result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    lbm_d2q9_node_collision_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .result_valid(result_valid), .result_stall(result_stall), .result(result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .mismatches(mismatches), .pending(pending)
    );

    // Output stall generator. The long hold is counted here so that the input side
    // keeps offering words and the pipeline backs up into item_stall.
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (hold_armed)
        begin
            hold_armed <= 0;
            hold_left <= 300;
            result_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else
        begin
            case (stall_mode)
                1:       result_stall <= ($urandom_range(0, 99) < 35);
                2:       result_stall <= (cyc % 7) < 3;
                default: result_stall <= 1'b0;
            endcase
        end
    end

    // Hard time limit: far above the slowest legal run.
    initial
    begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

    // one node word, held until taken
    task automatic send_node(in_word_t w);
        item_valid <= 1'b1;
        item <= w;
        do
            @(posedge clk);
        while (item_stall);
    endtask

    // random gaps between bursts; may leave valid low for a while
    task automatic maybe_gap();
        if ($urandom_range(0, 99) < 15)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // drain the pipeline, then write one register
    task automatic write_reg(logic [1:0] idx, logic [23:0] data);
        item_valid <= 1'b0;
        // let the checker count the last word taken before pending is read
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(logic [23:0] relax, logic [23:0] fx, logic [23:0] fy);
        write_reg(CFG_INV_RELAX, relax);
        write_reg(CFG_FORCE_X, fx);
        write_reg(CFG_FORCE_Y, fy);
    endtask

    function automatic in_word_t pack_node(int d [9]);
        return {24'(d[0]), 24'(d[1]), 24'(d[2]), 24'(d[3]), 24'(d[4]),
                24'(d[5]), 24'(d[6]), 24'(d[7]), 24'(d[8])};
    endfunction

    // Mostly near-equilibrium nodes with density around one, plus wide and
    // fully random words that drive saturation and non-positive density.
    function automatic in_word_t rand_node();
        int d [9];
        int k;
        k = $urandom_range(0, 99);
        for (int i = 0; i < 9; i++)
        begin
            if (k < 60)
                d[i] = (i == 0 ? ONE * 4 / 9 : (i < 5 ? ONE / 9 : ONE / 36))
                       + int'($urandom_range(0, ONE / 8)) - ONE / 16;
            else if (k < 80)
                d[i] = int'($urandom_range(0, 2 * ONE)) - ONE / 2;
            else if (k < 90)
                d[i] = int'($urandom_range(0, ONE)) - ONE;
            else
                d[i] = int'($urandom_range(0, 24'hFFFFFF)) - 8388608;
        end
        return pack_node(d);
    endfunction

    task automatic run_random(int n);
        for (int i = 0; i < n; i++)
        begin
            send_node(rand_node());
            maybe_gap();
        end
    endtask

    task automatic run_directed();
        int d [9];
        d = '{default: 0};
        send_node(pack_node(d));
        d = '{default: 8388607};
        send_node(pack_node(d));
        d = '{default: -8388608};
        send_node(pack_node(d));
        // equilibrium at rest, unit density
        d = '{466034, 116508, 116508, 116508, 116508, 29127, 29127, 29127, 29127};
        send_node(pack_node(d));
        // density exactly zero with nonzero momentum
        d = '{0, ONE, 0, -ONE, 0, 0, 0, 0, 0};
        send_node(pack_node(d));
        d = '{-ONE, ONE, 0, 0, 0, 0, 0, 0, 0};
        send_node(pack_node(d));
        // negative density
        d = '{-3 * ONE, ONE, ONE / 2, 0, 0, 0, 0, 0, 0};
        send_node(pack_node(d));
        // tiny or negative density, and large momentum over a large density
        d = '{0, 8388607, 0, 0, -8388608, 0, 0, 0, 0};
        send_node(pack_node(d));
        d = '{1, 0, 0, 0, 0, 0, 0, 0, 0};
        send_node(pack_node(d));
        d = '{0, 0, 0, 8388607, 8388607, -8388607, 0, 0, 0};
        send_node(pack_node(d));
        // density beyond the field range
        d = '{8388607, 8388607, 0, 0, 0, 0, 0, 0, 0};
        send_node(pack_node(d));
        d = '{ONE, 2 * ONE, -ONE, ONE / 3, 0, ONE, -ONE / 2, ONE / 4, 8388607};
        send_node(pack_node(d));
        d = '{-8388608, 8388607, -8388608, 8388607, -8388608, 8388607, -8388608,
              8388607, -8388608};
        send_node(pack_node(d));
        d = '{1, -1, 1, -1, 1, -1, 1, -1, 1};
        send_node(pack_node(d));
        item_valid <= 1'b0;
    endtask

    initial
    begin
        int waited;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset registers: inv_relax 1.0, no force
        run_directed();
        stall_mode = 1;
        run_random(60);

        // extremes: no relaxation, largest force
        set_regs(24'd0, 24'h7FFFFF, 24'h800000);
        run_directed();
        stall_mode = 2;
        run_random(60);

        // inv_relax 2.0 (zero source scale) and beyond it (negative source scale)
        set_regs(24'd2097152, 24'h800000, 24'h7FFFFF);
        stall_mode = 0;
        run_random(60);
        set_regs(24'h3FFFFF, 24'h000001, 24'hFFFFFF);
        run_directed();
        run_random(40);

        // out-of-list index must be ignored
        write_reg(2'd3, 24'hFFFFFF);
        run_random(20);

        // typical physical setting, with a long output hold mid-burst
        set_regs(24'd1600000, 24'd100, 24'hFFFF9C);
        stall_mode = 1;
        run_random(20);
        hold_armed = 1;
        run_random(60);

        // random register settings
        for (int p = 0; p < 4; p++)
        begin
            set_regs(24'($urandom_range(0, 24'h3FFFFF)),
                     ($urandom_range(0, 1) ? 24'($urandom) : 24'($urandom_range(0, 4095) - 2048)),
                     ($urandom_range(0, 1) ? 24'($urandom) : 24'($urandom_range(0, 4095) - 2048)));
            stall_mode = p % 3;
            run_random(50);
        end
        item_valid <= 1'b0;

        waited = 0;
        while (pending != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (40) @(posedge clk);

        if (mismatches == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: lbm_d2q9_node_collision.f
hdl/lbmc_pkg.sv
hdl/lbm_d2q9_node_collision.sv
tb/lbm_d2q9_node_collision_checker.sv
tb/lbm_d2q9_node_collision_tb.sv
